// ===== rtl/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

  // Default sizing of the frame map
  localparam int unsigned MAX_FRAMES_DEF  = 8192;
  localparam int unsigned FRAME_BYTES_DEF = 4096;

  // Bitmap word handled per step by the shared word unit
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned WORD_SH   = 5;
  localparam int unsigned CNT_W     = 6;

  // Configuration registers
  localparam int unsigned REG_W = 14;
  localparam logic [REG_W-1:0] TOTAL_RST = 14'd8192;
  localparam logic [REG_W-1:0] RESV_RST  = 14'd256;

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_RESV  = 1'b1;

  // Operation codes
  localparam logic [1:0] FUNC_ALLOC    = 2'd0;
  localparam logic [1:0] FUNC_FREE     = 2'd1;
  localparam logic [1:0] FUNC_RELEASE  = 2'd2;
  localparam logic [1:0] FUNC_MARK_ALL = 2'd3;

  localparam logic [7:0] REGION_USABLE = 8'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
    logic [31:0] range_length;
    logic [7:0]  region_type;
    logic        above_4g;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      alloc_address;
    logic             alloc_ok;
    logic [REG_W-1:0] used_count;
    logic [REG_W-1:0] free_count_out;
  } out_item_t;

  // Sequencer to word unit
  typedef struct packed {
    logic               alloc;
    logic [WORD_SH-1:0] lo_bit;
    logic [WORD_SH-1:0] hi_bit;
  } unit_req_t;

  // Word unit to sequencer
  typedef struct packed {
    logic               found;
    logic [WORD_SH-1:0] bit_idx;
    logic [CNT_W-1:0]   freed;
  } unit_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bitmap_frame_allocator.sv =====
// Bitmap page-frame allocator. One used bit per physical frame lives in a RAM of
// 32-bit words; a small sequencer walks that RAM through one shared word unit
// (first-free search, masked clear, freed-bit count). Ready is high only while
// idle, so one operation is in flight at a time; its result waits in an output
// register and the next operation may start meanwhile. After reset, and after a
// mark-all-used operation, a fill pass writes all ones to every word, one word a
// cycle; no transfer is taken meanwhile (configuration writes are). Free touches
// one word, or none when the frame is reserved or beyond the total; alloc scans
// from the word of the reserved count to the word holding the free frame or the
// last frame; release touches each word of the range, or none when the region is
// not usable, above 4 GiB, empty or past the map; mark-all-used returns its result
// after the fill. Each word step is the RAM's registered read (S_RD) followed by
// the read-modify-write (S_MOD). FRAME_BYTES must be a power of two. Write the
// registers only while the block is idle.
`default_nettype none

module bitmap_frame_allocator #(
  parameter int unsigned MAX_FRAMES  = bfa_pkg::MAX_FRAMES_DEF,
  parameter int unsigned FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration writes
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [bfa_pkg::REG_W-1:0]      cfg_data_i,
  // operation in
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire bfa_pkg::in_item_t              in_data_i,
  // result out
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output bfa_pkg::out_item_t                  out_data_o
);

  localparam int unsigned RW    = bfa_pkg::REG_W;
  localparam int unsigned WB    = bfa_pkg::WORD_BITS;
  localparam int unsigned WSH   = bfa_pkg::WORD_SH;
  localparam int unsigned FCW   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned DEPTH = (MAX_FRAMES + WB - 1) / WB;
  localparam int unsigned AWD   = $clog2(DEPTH);
  localparam int unsigned WCW   = FCW - WSH;
  localparam int unsigned SH    = $clog2(FRAME_BYTES);
  localparam int unsigned CMPW  = (FCW > RW) ? FCW : RW;
  localparam int unsigned AW    = FCW + SH;
  localparam logic [63:0] CAP64 = 64'(MAX_FRAMES) * 64'(FRAME_BYTES);
  localparam int unsigned CAPW  = $clog2(CAP64 + 64'd1);
  localparam int unsigned EW    = (CAPW > 33) ? CAPW : 33;
  localparam logic [EW-1:0] CAP = EW'(CAP64);

  typedef enum logic [7:0] {
    S_FILL  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RNG0  = 8'b0000_0100,
    S_RNG1  = 8'b0000_1000,
    S_SETUP = 8'b0001_0000,
    S_RD    = 8'b0010_0000,
    S_MOD   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [RW-1:0]        total_q, total_d;
  logic [RW-1:0]        resv_q, resv_d;
  logic [FCW-1:0]       fc_q, fc_d;          // free frame counter
  bfa_pkg::in_item_t    req_q, req_d;
  logic [FCW-1:0]       lo_q, lo_d;          // first frame of the span
  logic [FCW-1:0]       hi_q, hi_d;          // one past the last frame
  logic [FCW-1:0]       hm1_q, hm1_d;        // last frame
  logic [WCW-1:0]       w_q, w_d;            // current word
  logic [WCW-1:0]       lastw_q, lastw_d;
  logic                 alloc_q, alloc_d;
  logic [AWD-1:0]       fill_q, fill_d;
  logic                 pend_q, pend_d;      // mark-all result owed after fill
  logic [EW-1:0]        end_q, end_d;
  logic [31:0]          got_q, got_d;
  logic                 ok_q, ok_d;
  logic                 out_valid_q, out_valid_d;
  bfa_pkg::out_item_t   out_q, out_d;

  logic [FCW-1:0]       tot_eff, resv_eff;
  logic [31:0]          fr;
  logic                 fr_ok;
  logic [32:0]          end_sum, end_sat;
  logic [EW-1:0]        end_ext, first_b, last_b;
  logic [FCW-1:0]       span_m1, used_cnt;
  logic [AW-1:0]        frame_addr;

  logic                 ram_we, ram_re;
  logic [AWD-1:0]       ram_waddr;
  logic [WB-1:0]        ram_wdata, ram_rdata, unit_word;
  bfa_pkg::unit_req_t   unit_req;
  bfa_pkg::unit_rsp_t   unit_rsp;

  // Registers above MAX_FRAMES act as MAX_FRAMES
  assign tot_eff  = (CMPW'(total_q) > CMPW'(MAX_FRAMES)) ? FCW'(MAX_FRAMES) : FCW'(total_q);
  assign resv_eff = (CMPW'(resv_q) > CMPW'(MAX_FRAMES)) ? FCW'(MAX_FRAMES) : FCW'(resv_q);

  // Free: frame of the address, kept only inside [reserved, total)
  assign fr    = in_data_i.address >> SH;
  assign fr_ok = (fr >= 32'(resv_eff)) && (fr < 32'(tot_eff));

  // Release: end saturates at 4 GiB - 1, then caps at the map size
  assign end_sum = {1'b0, req_q.address} + {1'b0, req_q.range_length};
  assign end_sat = end_sum[32] ? 33'h0_FFFF_FFFF : end_sum;
  assign end_ext = EW'(end_sat);
  assign first_b = (EW'(req_q.address) + EW'(FRAME_BYTES - 1)) >> SH;
  assign last_b  = end_q >> SH;

  assign span_m1    = hi_q - FCW'(1);
  assign used_cnt   = (tot_eff > fc_q) ? (tot_eff - fc_q) : '0;
  assign frame_addr = AW'({w_q, unit_rsp.bit_idx}) << SH;

  // Word masks: only the ends of the span are partial
  assign unit_req.alloc  = alloc_q;
  assign unit_req.lo_bit = (w_q == lo_q[FCW-1:WSH]) ? lo_q[WSH-1:0] : '0;
  assign unit_req.hi_bit = (w_q == lastw_q) ? hm1_q[WSH-1:0] : '1;

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    resv_d      = resv_q;
    fc_d        = fc_q;
    req_d       = req_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    hm1_d       = hm1_q;
    w_d         = w_q;
    lastw_d     = lastw_q;
    alloc_d     = alloc_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    end_d       = end_q;
    got_d       = got_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = w_q[AWD-1:0];
    ram_wdata   = unit_word;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        bfa_pkg::CFG_TOTAL: total_d = cfg_data_i;
        bfa_pkg::CFG_RESV:  resv_d  = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_q;
        ram_wdata = '1;
        fill_d    = fill_q + AWD'(1);
        if (fill_q == AWD'(DEPTH - 1)) begin
          fill_d  = '0;
          pend_d  = 1'b0;
          state_d = pend_q ? S_DONE : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          got_d   = '0;
          ok_d    = 1'b0;
          alloc_d = 1'b0;
          case (in_data_i.func)
            bfa_pkg::FUNC_ALLOC: begin
              alloc_d = 1'b1;
              lo_d    = resv_eff;
              hi_d    = tot_eff;
              state_d = S_SETUP;
            end
            bfa_pkg::FUNC_FREE: begin
              lo_d    = fr_ok ? FCW'(fr) : '0;
              hi_d    = fr_ok ? FCW'(fr) + FCW'(1) : '0;
              state_d = S_SETUP;
            end
            bfa_pkg::FUNC_RELEASE: begin
              state_d = S_RNG0;
            end
            bfa_pkg::FUNC_MARK_ALL: begin
              fc_d    = '0;
              pend_d  = 1'b1;
              state_d = S_FILL;
            end
            default: ;
          endcase
        end
      end

      S_RNG0: begin
        end_d = (end_ext > CAP) ? CAP : end_ext;
        if ((req_q.region_type == bfa_pkg::REGION_USABLE) && !req_q.above_4g &&
            (req_q.range_length != '0) && (EW'(req_q.address) < CAP)) begin
          state_d = S_RNG1;
        end else begin
          state_d = S_DONE;
        end
      end

      S_RNG1: begin
        lo_d    = (first_b < EW'(resv_eff)) ? resv_eff : FCW'(first_b);
        hi_d    = (last_b > EW'(tot_eff)) ? tot_eff : FCW'(last_b);
        state_d = S_SETUP;
      end

      S_SETUP: begin
        w_d     = lo_q[FCW-1:WSH];
        hm1_d   = span_m1;
        lastw_d = span_m1[FCW-1:WSH];
        state_d = (lo_q >= hi_q) ? S_DONE : S_RD;
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_MOD;
      end

      S_MOD: begin
        ram_we = 1'b1;
        if (alloc_q && unit_rsp.found) begin
          fc_d    = fc_q - FCW'(1);
          got_d   = 32'(frame_addr);
          ok_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          if (!alloc_q) begin
            fc_d = fc_q + FCW'(unit_rsp.freed);
          end
          if (w_q == lastw_q) begin
            state_d = S_DONE;
          end else begin
            w_d     = w_q + WCW'(1);
            state_d = S_RD;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.alloc_address  = got_q;
          out_d.alloc_ok       = ok_q;
          out_d.used_count     = RW'(used_cnt);
          out_d.free_count_out = RW'(fc_q);
          state_d              = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      total_q     <= bfa_pkg::TOTAL_RST;
      resv_q      <= bfa_pkg::RESV_RST;
      fc_q        <= '0;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      resv_q      <= resv_d;
      fc_q        <= fc_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    hm1_q   <= hm1_d;
    w_q     <= w_d;
    lastw_q <= lastw_d;
    alloc_q <= alloc_d;
    end_q   <= end_d;
    got_q   <= got_d;
    ok_q    <= ok_d;
    out_q   <= out_d;
  end

  bfa_ram #(
    .WIDTH (WB),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (w_q[AWD-1:0]),
    .rdata_o (ram_rdata)
  );

  bfa_word_unit u_word (
    .word_i (ram_rdata),
    .req_i  (unit_req),
    .word_o (unit_word),
    .rsp_o  (unit_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks

  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= FCW'(MAX_FRAMES))
    else $error("free counter above map size");

  a_alloc_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && alloc_q && unit_rsp.found) |=> (fc_q == $past(fc_q) - FCW'(1)))
    else $error("alloc hit did not take one free frame");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.alloc_ok) |-> (out_data_o.alloc_address == '0))
    else $error("failed or non-alloc result carries an address");

  a_mark_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.func == bfa_pkg::FUNC_MARK_ALL)
      |=> (fc_q == '0 && state_q == S_FILL))
    else $error("mark-all did not restart the map");

endmodule

`default_nettype wire

// ===== rtl/bfa_ram.sv =====
`default_nettype none

module bfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bfa_word_unit.sv =====
`default_nettype none

// One bitmap word per call: first-free search and set, or clear under a mask
module bfa_word_unit (
  input  wire logic [bfa_pkg::WORD_BITS-1:0] word_i,
  input  wire bfa_pkg::unit_req_t            req_i,
  output logic      [bfa_pkg::WORD_BITS-1:0] word_o,
  output bfa_pkg::unit_rsp_t                 rsp_o
);

  localparam int unsigned WB  = bfa_pkg::WORD_BITS;
  localparam int unsigned WSH = bfa_pkg::WORD_SH;
  localparam int unsigned CW  = bfa_pkg::CNT_W;

  logic [WB-1:0]  ones;
  logic [WB-1:0]  mask;
  logic [WB-1:0]  cand;
  logic [WB-1:0]  hit;
  logic [WSH-1:0] idx;
  logic [CW-1:0]  cnt;

  assign ones = '1;

  always_comb begin
    mask = (ones << req_i.lo_bit) & (ones >> (WSH'(WB - 1) - req_i.hi_bit));
    cand = ~word_i & mask;
    idx  = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = WSH'(i);
      end
    end
    hit = '0;
    hit[idx] = 1'b1;
    cnt = '0;
    for (int i = 0; i < WB; i++) begin
      cnt = cnt + CW'(word_i[i] & mask[i]);
    end

    if (req_i.alloc) begin
      word_o = (|cand) ? (word_i | hit) : word_i;
    end else begin
      word_o = word_i & ~mask;
    end

    rsp_o.found   = |cand;
    rsp_o.bit_idx = idx;
    rsp_o.freed   = cnt;
  end

endmodule

`default_nettype wire

// ===== bench/bitmap_frame_allocator_tb.sv =====
`default_nettype none

module bitmap_frame_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_FRAMES  = bfa_pkg::MAX_FRAMES_DEF;
  localparam int unsigned FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF;
  localparam int unsigned REG_W       = bfa_pkg::REG_W;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_OPS   = 178;

  // Directed rows are either an operation transfer or a register write
  typedef enum logic {ROW_OP, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic               reg_idx;
    logic [REG_W-1:0]   reg_val;
    bfa_pkg::in_item_t  op;
    bit                 typed;  // want holds a hand-written result
    bfa_pkg::out_item_t want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [REG_W-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  bfa_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  bfa_pkg::out_item_t out_data_o;

  bitmap_frame_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5ns clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Allocator model: its own used map, free counter and register copies.
  // ---------------------------------------------------------------------------
  bit                 frame_used [MAX_FRAMES];
  int unsigned        free_frames;
  logic [REG_W-1:0]   cur_total;
  logic [REG_W-1:0]   cur_resv;

  bfa_pkg::out_item_t due_results [$];  // results owed by the block, oldest first
  int unsigned        mismatches;

  // Hand-written expectation travelling with the operation currently offered
  bit                 row_typed;
  bfa_pkg::out_item_t row_want;

  // While set, neither side inserts gaps
  bit                 no_idle;

  function automatic int unsigned frames_clamped(input logic [REG_W-1:0] v);
    return (v > MAX_FRAMES) ? MAX_FRAMES : 32'(v);
  endfunction

  function automatic void fill_used_map();
    foreach (frame_used[i]) frame_used[i] = 1'b1;
    free_frames = 0;
  endfunction

  // One operation against the model; returns the result it owes
  function automatic bfa_pkg::out_item_t apply_op(input bfa_pkg::in_item_t op);
    bfa_pkg::out_item_t res;
    int unsigned        tot;
    int unsigned        rsv;
    int unsigned        f;
    longint unsigned    cap;
    longint unsigned    start;
    longint unsigned    stop;
    longint unsigned    first;
    longint unsigned    last;
    tot = frames_clamped(cur_total);
    rsv = frames_clamped(cur_resv);
    res = '0;
    case (op.func)
      bfa_pkg::FUNC_ALLOC: begin
        // lowest free frame in [reserved, total)
        for (f = rsv; f < tot && !res.alloc_ok; f++) begin
          if (!frame_used[f]) begin
            frame_used[f]     = 1'b1;
            free_frames--;
            res.alloc_address = f * FRAME_BYTES;
            res.alloc_ok      = 1'b1;
          end
        end
      end
      bfa_pkg::FUNC_FREE: begin
        f = op.address / FRAME_BYTES;
        if (f >= rsv && f < tot && frame_used[f]) begin
          frame_used[f] = 1'b0;
          free_frames++;
        end
      end
      bfa_pkg::FUNC_RELEASE: begin
        cap   = 64'(MAX_FRAMES) * 64'(FRAME_BYTES);
        start = 64'(op.address);
        stop  = start + 64'(op.range_length);
        if (op.region_type == bfa_pkg::REGION_USABLE && !op.above_4g &&
            op.range_length != 0 && start < cap) begin
          // end saturates at 4 GiB - 1 before the map cap applies
          if (stop > 64'hFFFF_FFFF) stop = 64'hFFFF_FFFF;
          if (stop > cap) stop = cap;
          // whole frames only: round the base up, the end down
          first = (start + 64'(FRAME_BYTES) - 64'd1) / 64'(FRAME_BYTES);
          last  = stop / 64'(FRAME_BYTES);
          if (first < 64'(rsv)) first = 64'(rsv);
          if (last > 64'(tot)) last = 64'(tot);
          for (f = 32'(first); 64'(f) < last; f++) begin
            if (frame_used[f]) begin
              frame_used[f] = 1'b0;
              free_frames++;
            end
          end
        end
      end
      default: fill_used_map();
    endcase
    res.used_count     = (tot > free_frames) ? REG_W'(tot - free_frames) : '0;
    res.free_count_out = REG_W'(free_frames);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor. Handshakes are sampled at the rising edge; inputs only move at the
  // falling edge, so the values read here are the ones the block saw.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    bfa_pkg::out_item_t predicted;
    bfa_pkg::out_item_t oldest;
    if (rst_ni) begin
      // result side first so a fresh transfer can never pair with this edge
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with none owed: %h", out_data_o));
        end else begin
          oldest = due_results.pop_front();
          if (out_data_o.alloc_address !== oldest.alloc_address)
            report_mismatch($sformatf("alloc_address got %h want %h",
                                      out_data_o.alloc_address, oldest.alloc_address));
          if (out_data_o.alloc_ok !== oldest.alloc_ok)
            report_mismatch($sformatf("alloc_ok got %b want %b",
                                      out_data_o.alloc_ok, oldest.alloc_ok));
          if (out_data_o.used_count !== oldest.used_count)
            report_mismatch($sformatf("used_count got %0d want %0d",
                                      out_data_o.used_count, oldest.used_count));
          if (out_data_o.free_count_out !== oldest.free_count_out)
            report_mismatch($sformatf("free_count_out got %0d want %0d",
                                      out_data_o.free_count_out, oldest.free_count_out));
        end
      end
      if (in_valid_i && in_ready_o) begin
        predicted = apply_op(in_data_i);
        due_results.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result sink: ready toggles at the falling edge with random stalls
  initial begin : result_sink
    int unsigned hold;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      hold = pick_gap();
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one operation and hold it until the transfer. Valid is only lowered
  // when a gap follows, so it never drops and rises within one step.
  task automatic send_op(input bfa_pkg::in_item_t op, input bit typed,
                         input bfa_pkg::out_item_t want);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= op;
    in_valid_i <= 1'b1;
    row_typed  <= typed;
    row_want   <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering and wait for every owed result and an idle block
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0 || in_ready_o !== 1'b1) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [REG_W-1:0] val);
    drain_results();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == bfa_pkg::CFG_TOTAL) cur_total = val;
    else cur_resv = val;
  endtask

  function automatic stim_row_t op_row(input logic [1:0] func, input logic [31:0] addr,
                                       input logic [31:0] len, input logic [7:0] rtype,
                                       input logic hi);
    stim_row_t r;
    r                 = '{kind: ROW_OP, default: '0};
    r.op.func         = func;
    r.op.address      = addr;
    r.op.range_length = len;
    r.op.region_type  = rtype;
    r.op.above_4g     = hi;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input stim_row_t r, input logic [31:0] addr,
                                          input logic ok, input int unsigned used,
                                          input int unsigned free_n);
    stim_row_t t;
    t                     = r;
    t.typed               = 1'b1;
    t.want.alloc_address  = addr;
    t.want.alloc_ok       = ok;
    t.want.used_count     = REG_W'(used);
    t.want.free_count_out = REG_W'(free_n);
    return t;
  endfunction

  function automatic stim_row_t reg_row(input logic idx, input logic [REG_W-1:0] val);
    stim_row_t r;
    r         = '{kind: ROW_REG, default: '0};
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Random operation, biased towards frames the current settings manage
  function automatic bfa_pkg::in_item_t rand_op();
    bfa_pkg::in_item_t op;
    logic [95:0]       noise;
    int unsigned       span;
    int unsigned       pick;
    int unsigned       fr;
    span           = frames_clamped(cur_total);
    op             = '0;
    op.region_type = bfa_pkg::REGION_USABLE;
    pick           = $urandom_range(0, 99);
    if (pick < 40) begin
      op.func = bfa_pkg::FUNC_ALLOC;
    end else if (pick < 65) begin
      op.func    = bfa_pkg::FUNC_FREE;
      fr         = $urandom_range(0, span + 8);
      op.address = fr * FRAME_BYTES + $urandom_range(0, FRAME_BYTES - 1);
    end else if (pick < 80) begin
      op.func    = bfa_pkg::FUNC_RELEASE;
      fr         = $urandom_range(0, span + 8);
      op.address = fr * FRAME_BYTES;
      if ($urandom_range(0, 3) == 0) op.address += $urandom_range(1, FRAME_BYTES - 1);
      case ($urandom_range(0, 7))
        0:       op.range_length = (span + 1) * FRAME_BYTES;
        1:       op.range_length = $urandom;
        default: op.range_length = $urandom_range(1, 48) * FRAME_BYTES +
                                   ($urandom_range(0, 1) ? $urandom_range(0, FRAME_BYTES - 1)
                                                         : 0);
      endcase
      if ($urandom_range(0, 9) == 0) op.region_type = 8'($urandom_range(0, 255));
      op.above_4g = ($urandom_range(0, 19) == 0);
    end else if (pick < 83) begin
      op.func = bfa_pkg::FUNC_MARK_ALL;
    end else begin
      // raw noise over every field and bit
      noise = {$urandom, $urandom, $urandom};
      op    = noise[$bits(bfa_pkg::in_item_t)-1:0];
    end
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t        dir_rows [$];
    logic [REG_W-1:0] tot;
    logic [REG_W-1:0] rsv;
    int unsigned      p;
    int unsigned      k;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = bfa_pkg::CFG_TOTAL;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    row_typed   = 1'b0;
    row_want    = '0;
    no_idle     = 1'b0;
    mismatches  = 0;
    fill_used_map();
    cur_total   = bfa_pkg::TOTAL_RST;
    cur_resv    = bfa_pkg::RESV_RST;

    // After reset: total 8192, reserved 256, every frame used
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_ALLOC, 0, 0, 0, 0), 0, 0, 8192, 0));
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_FREE, 32'h0010_0000, 0, 0, 0),
                                 0, 0, 8191, 1));
    // freeing a frame that is already free, address inside the frame
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_FREE, 32'h0010_0FFF, 0, 0, 0),
                                 0, 0, 8191, 1));
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_ALLOC, 0, 0, 0, 0),
                                 32'h0010_0000, 1, 8192, 0));
    // reserved frame and frame beyond the map are left alone
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_FREE, 32'h0000_0FFF, 0, 0, 0),
                                 0, 0, 8192, 0));
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_FREE, 32'hFFFF_FFFF, 0, 0, 0),
                                 0, 0, 8192, 0));
    // release of a non-usable, high, empty and out-of-map region: no effect
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_RELEASE, 32'h0020_0000, 32'h0001_0000,
                                        8'hFF, 0), 0, 0, 8192, 0));
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_RELEASE, 32'h0020_0000, 32'h0001_0000,
                                        bfa_pkg::REGION_USABLE, 1), 0, 0, 8192, 0));
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_RELEASE, 32'h0020_0000, 0,
                                        bfa_pkg::REGION_USABLE, 0), 0, 0, 8192, 0));
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_RELEASE, 32'h0200_0000, 32'h0000_1000,
                                        bfa_pkg::REGION_USABLE, 0), 0, 0, 8192, 0));
    // unaligned base: the partial frames at both ends stay used
    dir_rows.push_back(op_row(bfa_pkg::FUNC_RELEASE, 32'h0010_0001, 32'h0000_3000,
                              bfa_pkg::REGION_USABLE, 0));
    // end wraps past 4 GiB: saturate, then cap at the map size
    dir_rows.push_back(op_row(bfa_pkg::FUNC_RELEASE, 32'h01FF_F000, 32'hFFFF_FFFF,
                              bfa_pkg::REGION_USABLE, 0));
    // whole address space, reserved frames excluded
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_RELEASE, 0, 32'hFFFF_FFFF,
                                        bfa_pkg::REGION_USABLE, 0), 0, 0, 256, 7936));
    dir_rows.push_back(op_row(bfa_pkg::FUNC_ALLOC, 0, 0, 0, 0));
    dir_rows.push_back(op_row(bfa_pkg::FUNC_FREE, 32'h0010_0000, 0, 0, 0));
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_MARK_ALL, 0, 0, 0, 0), 0, 0, 8192, 0));
    // no reserved frames: frame 0 comes back as address 0 with ok set
    dir_rows.push_back(reg_row(bfa_pkg::CFG_RESV, '0));
    dir_rows.push_back(op_row(bfa_pkg::FUNC_RELEASE, 0, 32'h0000_2000,
                              bfa_pkg::REGION_USABLE, 0));
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_ALLOC, 0, 0, 0, 0), 0, 1, 8191, 1));
    // register values beyond the map clamp to it
    dir_rows.push_back(reg_row(bfa_pkg::CFG_TOTAL, '1));
    dir_rows.push_back(reg_row(bfa_pkg::CFG_RESV, '1));
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_ALLOC, 0, 0, 0, 0), 0, 0, 8191, 1));
    dir_rows.push_back(op_row(bfa_pkg::FUNC_FREE, 32'h0000_1000, 0, 0, 0));
    // total shrunk below the free count: used count saturates at zero
    dir_rows.push_back(reg_row(bfa_pkg::CFG_TOTAL, '0));
    dir_rows.push_back(reg_row(bfa_pkg::CFG_RESV, '0));
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_ALLOC, 0, 0, 0, 0), 0, 0, 0, 1));
    dir_rows.push_back(op_row(bfa_pkg::FUNC_RELEASE, 0, 32'h2000_0000,
                              bfa_pkg::REGION_USABLE, 0));
    dir_rows.push_back(typed_row(op_row(bfa_pkg::FUNC_MARK_ALL, 0, 0, 0, 0), 0, 0, 0, 0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under its own register setting. Small totals keep
    // the failing alloc scans short; the full map gets three phases.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin tot = 14'd8192;  rsv = 14'd256;  end
        1:       begin tot = 14'd512;   rsv = 14'd0;    end
        2:       begin tot = 14'd300;   rsv = 14'd17;   end
        3:       begin tot = 14'd16383; rsv = 14'd8000; end
        4:       begin tot = 14'd64;    rsv = 14'd64;   end
        5:       begin tot = 14'd1000;  rsv = 14'd1200; end
        6:       begin tot = 14'd8192;  rsv = 14'd0;    end
        default: begin
          tot = REG_W'($urandom_range(1, 2048));
          rsv = REG_W'($urandom_range(0, 80));
        end
      endcase
      write_reg(bfa_pkg::CFG_TOTAL, tot);
      write_reg(bfa_pkg::CFG_RESV, rsv);
      no_idle = ($urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_OPS; k++) begin
        // hold off mid-phase until the block has handed back everything
        if (k == PHASE_OPS / 3) drain_results();
        send_op(rand_op(), 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    drain_results();
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("bitmap_frame_allocator test passed");
    end else begin
      $display("bitmap_frame_allocator test failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin : watchdog
    #40ms;
    $display("bitmap_frame_allocator test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bfa_word_unit.sv
rtl/bitmap_frame_allocator.sv
bench/bitmap_frame_allocator_tb.sv
